FILE: rtl/euler_xyz_vector_rotation_top_defines.svh
// ----------------------------------------------------------------------------
// Euler XYZ rotation - assertion macros
// Shared property shorthands, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef EULER_XYZ_VECTOR_ROTATION_TOP_DEFINES_SVH
`define EULER_XYZ_VECTOR_ROTATION_TOP_DEFINES_SVH

// same-cycle implication
`define EVR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/evr_pkg.sv
// ----------------------------------------------------------------------------
// Euler XYZ rotation - package
// Types shared by front and back; CORDIC constants, trig rounding for front.
// ----------------------------------------------------------------------------
package evr_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int TRIG_FRAC    = 14;
  localparam int TRIG_W       = 16;
  localparam int CX_W         = 34;
  localparam int CZ_W         = 32;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [CX_W-1:0]   cx_t;
  typedef logic signed [CZ_W-1:0]   cz_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam cx_t CORDIC_GAIN = 34'sh026DD3B6A;
  localparam cx_t TRIG_ONE    = cx_t'(1) <<< TRIG_FRAC;
  localparam cx_t TRIG_RND    = cx_t'(1) <<< (29 - TRIG_FRAC);

  localparam logic [31:0] ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  // Q3.30 to Q1.14, round half up, clamp to +/- unity
  function automatic trig_t clamp_trig(input cx_t v);
    cx_t r;
    r = (v + TRIG_RND) >>> (30 - TRIG_FRAC);
    if (r > TRIG_ONE) begin
      r = TRIG_ONE;
    end else if (r < -TRIG_ONE) begin
      r = -TRIG_ONE;
    end
    return trig_t'(r);
  endfunction

endpackage

FILE: rtl/evr_trig.sv
// ----------------------------------------------------------------------------
// Euler XYZ rotation - front end
// Takes requests, runs three pipelined CORDIC lanes for cos/sin, carries point.
// ----------------------------------------------------------------------------
module evr_trig #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic        [ANGLE_WIDTH-1:0] in_angle_x,
  input  logic        [ANGLE_WIDTH-1:0] in_angle_y,
  input  logic        [ANGLE_WIDTH-1:0] in_angle_z,
  input  logic                          fifo_full,
  output logic                          fe_valid,
  output logic signed [COORD_WIDTH-1:0] fe_x,
  output logic signed [COORD_WIDTH-1:0] fe_y,
  output logic signed [COORD_WIDTH-1:0] fe_z,
  output evr_pkg::trig_t                fe_cos [3],
  output evr_pkg::trig_t                fe_sin [3]
);

  localparam int NS = evr_pkg::CORDIC_STEPS;

  logic                          en;
  logic [NS:0]                   vld_r;
  logic                          vld_o_r;
  logic signed [COORD_WIDTH-1:0] px_r [0:NS];
  logic signed [COORD_WIDTH-1:0] py_r [0:NS];
  logic signed [COORD_WIDTH-1:0] pz_r [0:NS];
  evr_pkg::cx_t                  cx_r [3][0:NS];
  evr_pkg::cx_t                  cy_r [3][0:NS];
  evr_pkg::cz_t                  cz_r [3][0:NS];
  logic [1:0]                    q_r  [3][0:NS];
  logic [ANGLE_WIDTH-1:0]        ang  [3];
  logic [31:0]                   aln  [3];
  evr_pkg::cx_t                  cr   [3];
  evr_pkg::cx_t                  sr   [3];
  logic signed [COORD_WIDTH-1:0] fe_x_r, fe_y_r, fe_z_r;
  evr_pkg::trig_t                cos_r [3];
  evr_pkg::trig_t                sin_r [3];

  assign en       = !(vld_o_r && fifo_full);
  assign in_stall = !en;

  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      aln[k] = {ang[k], {(32-ANGLE_WIDTH){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_o_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[NS-1:0], in_valid};
      vld_o_r <= vld_r[NS];
    end
  end

  // capture: nearest quarter turn split off, residual sign-extended
  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= in_point_x;
      py_r[0] <= in_point_y;
      pz_r[0] <= in_point_z;
      for (int k = 0; k < 3; k++) begin
        q_r[k][0]  <= aln[k][31:30] + {1'b0, aln[k][29]};
        cz_r[k][0] <= {{2{aln[k][29]}}, aln[k][29:0]};
        cx_r[k][0] <= evr_pkg::CORDIC_GAIN;
        cy_r[k][0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        px_r[i+1] <= px_r[i];
        py_r[i+1] <= py_r[i];
        pz_r[i+1] <= pz_r[i];
        for (int k = 0; k < 3; k++) begin
          q_r[k][i+1] <= q_r[k][i];
          if (!cz_r[k][i][evr_pkg::CZ_W-1]) begin
            cx_r[k][i+1] <= cx_r[k][i] - (cy_r[k][i] >>> i);
            cy_r[k][i+1] <= cy_r[k][i] + (cx_r[k][i] >>> i);
            cz_r[k][i+1] <= cz_r[k][i] - evr_pkg::cz_t'(evr_pkg::ATAN[i]);
          end else begin
            cx_r[k][i+1] <= cx_r[k][i] + (cy_r[k][i] >>> i);
            cy_r[k][i+1] <= cy_r[k][i] - (cx_r[k][i] >>> i);
            cz_r[k][i+1] <= cz_r[k][i] + evr_pkg::cz_t'(evr_pkg::ATAN[i]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (q_r[k][NS])
        2'd0: begin
          cr[k] = cx_r[k][NS];
          sr[k] = cy_r[k][NS];
        end
        2'd1: begin
          cr[k] = -cy_r[k][NS];
          sr[k] = cx_r[k][NS];
        end
        2'd2: begin
          cr[k] = -cx_r[k][NS];
          sr[k] = -cy_r[k][NS];
        end
        default: begin
          cr[k] = cy_r[k][NS];
          sr[k] = -cx_r[k][NS];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fe_x_r <= px_r[NS];
      fe_y_r <= py_r[NS];
      fe_z_r <= pz_r[NS];
      for (int k = 0; k < 3; k++) begin
        cos_r[k] <= evr_pkg::clamp_trig(cr[k]);
        sin_r[k] <= evr_pkg::clamp_trig(sr[k]);
      end
    end
  end

  assign fe_valid = vld_o_r;
  assign fe_x     = fe_x_r;
  assign fe_y     = fe_y_r;
  assign fe_z     = fe_z_r;
  assign fe_cos   = cos_r;
  assign fe_sin   = sin_r;

endmodule

FILE: rtl/evr_fifo.sv
// ----------------------------------------------------------------------------
// Euler XYZ rotation - decoupling queue
// Short first-in first-out queue between front end and rotation back end.
// ----------------------------------------------------------------------------
module evr_fifo #(
  parameter int DW = 192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DW-1:0]       wr_data,
  input  logic                pop,
  output logic [DW-1:0]       rd_data,
  output evr_pkg::fifo_stat_t stat
);

  localparam int AW = evr_pkg::FIFO_AW;

  logic [DW-1:0] mem_r [evr_pkg::FIFO_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rp_r];
  assign stat.full  = (cnt_r == (AW+1)'(evr_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

FILE: rtl/evr_rot.sv
// ----------------------------------------------------------------------------
// Euler XYZ rotation - back end
// Six-stage rotate about X, Y, Z: multiply, then round and saturate, per axis.
// ----------------------------------------------------------------------------
module evr_rot #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          be_valid,
  output logic                          be_ready,
  input  logic signed [COORD_WIDTH-1:0] be_x,
  input  logic signed [COORD_WIDTH-1:0] be_y,
  input  logic signed [COORD_WIDTH-1:0] be_z,
  input  evr_pkg::trig_t                be_cos [3],
  input  evr_pkg::trig_t                be_sin [3],
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_rotated_x,
  output logic signed [COORD_WIDTH-1:0] out_rotated_y,
  output logic signed [COORD_WIDTH-1:0] out_rotated_z
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + evr_pkg::TRIG_W;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] HI  = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] LO  = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (evr_pkg::TRIG_FRAC - 1);

  function automatic logic signed [CW-1:0] comb_sat(
    input logic signed [PW-1:0] p,
    input logic signed [PW-1:0] q,
    input logic                 sub
  );
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] r;
    s = sub ? (SW'(p) - SW'(q)) : (SW'(p) + SW'(q));
    r = (s + RND) >>> evr_pkg::TRIG_FRAC;
    if (r > HI) begin
      r = HI;
    end else if (r < LO) begin
      r = LO;
    end
    return r[CW-1:0];
  endfunction

  logic                 en;
  logic [5:0]           vld_r;
  logic signed [PW-1:0] pa_r [4];
  logic signed [PW-1:0] pc_r [4];
  logic signed [PW-1:0] pe_r [4];
  logic signed [CW-1:0] xa_r, xb_r, yb_r, zb_r, yc_r, xd_r, yd_r, zd_r, ze_r;
  logic signed [CW-1:0] ox_r, oy_r, oz_r;
  evr_pkg::trig_t       cy_a_r, sy_a_r, cz_a_r, sz_a_r;
  evr_pkg::trig_t       cy_b_r, sy_b_r, cz_b_r, sz_b_r;
  evr_pkg::trig_t       cz_c_r, sz_c_r, cz_d_r, sz_d_r;

  assign en       = !(vld_r[5] && out_stall);
  assign be_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], be_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // about X
      pa_r[0] <= be_y * be_cos[0];
      pa_r[1] <= be_z * be_sin[0];
      pa_r[2] <= be_z * be_cos[0];
      pa_r[3] <= be_y * be_sin[0];
      xa_r    <= be_x;
      cy_a_r  <= be_cos[1];
      sy_a_r  <= be_sin[1];
      cz_a_r  <= be_cos[2];
      sz_a_r  <= be_sin[2];

      yb_r   <= comb_sat(pa_r[0], pa_r[1], 1'b1);
      zb_r   <= comb_sat(pa_r[2], pa_r[3], 1'b0);
      xb_r   <= xa_r;
      cy_b_r <= cy_a_r;
      sy_b_r <= sy_a_r;
      cz_b_r <= cz_a_r;
      sz_b_r <= sz_a_r;

      // about Y
      pc_r[0] <= xb_r * cy_b_r;
      pc_r[1] <= zb_r * sy_b_r;
      pc_r[2] <= zb_r * cy_b_r;
      pc_r[3] <= xb_r * sy_b_r;
      yc_r    <= yb_r;
      cz_c_r  <= cz_b_r;
      sz_c_r  <= sz_b_r;

      xd_r   <= comb_sat(pc_r[0], pc_r[1], 1'b0);
      zd_r   <= comb_sat(pc_r[2], pc_r[3], 1'b1);
      yd_r   <= yc_r;
      cz_d_r <= cz_c_r;
      sz_d_r <= sz_c_r;

      // about Z
      pe_r[0] <= xd_r * cz_d_r;
      pe_r[1] <= yd_r * sz_d_r;
      pe_r[2] <= yd_r * cz_d_r;
      pe_r[3] <= xd_r * sz_d_r;
      ze_r    <= zd_r;

      ox_r <= comb_sat(pe_r[0], pe_r[1], 1'b1);
      oy_r <= comb_sat(pe_r[2], pe_r[3], 1'b0);
      oz_r <= ze_r;
    end
  end

  assign out_valid     = vld_r[5];
  assign out_rotated_x = ox_r;
  assign out_rotated_y = oy_r;
  assign out_rotated_z = oz_r;

endmodule

FILE: rtl/euler_xyz_vector_rotation_top.sv
// ----------------------------------------------------------------------------
// Euler XYZ rotation - top level
// Rotates a fixed-point point about X, then Y, then Z by three binary angles.
// ----------------------------------------------------------------------------
// One request per cycle is sustained while the output is not stalled. A request
// passes through the CORDIC front end (capture, 28 iterations, quadrant map and
// rounding), the four-entry queue, and the rotation back end (one multiply and
// one round/saturate stage per axis). Each rotation stage saturates to the
// coordinate range.
module euler_xyz_vector_rotation_top #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic        [ANGLE_WIDTH-1:0] in_angle_x,
  input  logic        [ANGLE_WIDTH-1:0] in_angle_y,
  input  logic        [ANGLE_WIDTH-1:0] in_angle_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_rotated_x,
  output logic signed [COORD_WIDTH-1:0] out_rotated_y,
  output logic signed [COORD_WIDTH-1:0] out_rotated_z
);

`include "euler_xyz_vector_rotation_top_defines.svh"

  localparam int CW = COORD_WIDTH;
  localparam int TW = evr_pkg::TRIG_W;
  localparam int DW = 3*CW + 6*TW;

  logic                          fe_valid;
  logic                          fe_push;
  logic                          be_ready;
  logic                          be_pop;
  logic signed [CW-1:0]          fe_x, fe_y, fe_z;
  evr_pkg::trig_t                fe_cos [3];
  evr_pkg::trig_t                fe_sin [3];
  logic [DW-1:0]                 wr_data, rd_data;
  evr_pkg::fifo_stat_t           fst;
  logic signed [CW-1:0]          be_x, be_y, be_z;
  evr_pkg::trig_t                be_cos [3];
  evr_pkg::trig_t                be_sin [3];

  evr_trig #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_trig (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_point_z (in_point_z),
    .in_angle_x (in_angle_x),
    .in_angle_y (in_angle_y),
    .in_angle_z (in_angle_z),
    .fifo_full  (fst.full),
    .fe_valid   (fe_valid),
    .fe_x       (fe_x),
    .fe_y       (fe_y),
    .fe_z       (fe_z),
    .fe_cos     (fe_cos),
    .fe_sin     (fe_sin)
  );

  assign fe_push = fe_valid && !fst.full;
  assign wr_data = {fe_x, fe_y, fe_z, fe_cos[0], fe_sin[0], fe_cos[1], fe_sin[1],
                    fe_cos[2], fe_sin[2]};

  evr_fifo #(
    .DW(DW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fe_push),
    .wr_data (wr_data),
    .pop     (be_pop),
    .rd_data (rd_data),
    .stat    (fst)
  );

  assign be_pop = !fst.empty && be_ready;
  assign {be_x, be_y, be_z, be_cos[0], be_sin[0], be_cos[1], be_sin[1],
          be_cos[2], be_sin[2]} = rd_data;

  evr_rot #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_rot (
    .clk           (clk),
    .rst_n         (rst_n),
    .be_valid      (!fst.empty),
    .be_ready      (be_ready),
    .be_x          (be_x),
    .be_y          (be_y),
    .be_z          (be_z),
    .be_cos        (be_cos),
    .be_sin        (be_sin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rotated_x (out_rotated_x),
    .out_rotated_y (out_rotated_y),
    .out_rotated_z (out_rotated_z)
  );

  `EVR_ASSERT_IMPLIES(a_stall_only_full, in_stall, fst.full, "input stalled with queue not full")
  `EVR_ASSERT_NEXT(a_empty_holds, fst.empty && !fe_push, fst.empty, "queue filled without push")
  `EVR_ASSERT_NEXT(a_full_holds, fst.full && !be_pop, fst.full, "queue drained without pop")

endmodule

FILE: verif/tb_euler_xyz_vector_rotation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler XYZ rotation - testbench
// Drives points and angles through the rotator, predicts each rotated point
// with an independent CORDIC and fixed-point rotation, and checks in order.
// ----------------------------------------------------------------------------
module tb_euler_xyz_vector_rotation_top;

  localparam int CW    = 32;
  localparam int AW    = 16;
  localparam int STEPS = 28;
  localparam int LATENCY = 40;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    logic [AW-1:0]        ax;
    logic [AW-1:0]        ay;
    logic [AW-1:0]        az;
  } request_t;

  typedef struct packed {
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rz;
  } rotated_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [AW-1:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_rotated_x, out_rotated_y, out_rotated_z;

  rotated_t expected_points[$];
  int       error_count = 0;
  bit       calm = 1'b0;

  const longint arctan_table [STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005
  };

  euler_xyz_vector_rotation_top dut (.*);

  always #4 clk = ~clk;

  function automatic longint to_unit(longint v);
    longint r;
    r = (v + (64'sd1 <<< 15)) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic void sin_cos(input logic [AW-1:0] ang, output longint c,
                                  output longint s);
    logic [31:0] a, ru;
    logic [1:0]  quad;
    longint x, y, z, dx, dy, cr, sr;
    a = {ang, 16'h0};
    quad = 2'((a + 32'h20000000) >> 30);
    ru = a - ({30'h0, quad} << 30);
    z = longint'($signed(ru));
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_table[i];
      end else begin
        x += dx; y -= dy; z += arctan_table[i];
      end
    end
    case (quad)
      2'd0: begin cr = x;  sr = y;  end
      2'd1: begin cr = -y; sr = x;  end
      2'd2: begin cr = -x; sr = -y; end
      default: begin cr = y; sr = -x; end
    endcase
    c = to_unit(cr);
    s = to_unit(sr);
  endfunction

  function automatic longint round_sat(longint p, longint q);
    longint r;
    r = (p + q + 64'sd8192) >>> 14;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic rotated_t rotate_point(request_t rq);
    longint x, y, z, c, s, nx, ny, nz;
    rotated_t res;
    x = rq.px; y = rq.py; z = rq.pz;
    sin_cos(rq.ax, c, s);
    ny = round_sat(y * c, -(z * s));
    nz = round_sat(z * c, y * s);
    y = ny; z = nz;
    sin_cos(rq.ay, c, s);
    nx = round_sat(x * c, z * s);
    nz = round_sat(z * c, -(x * s));
    x = nx; z = nz;
    sin_cos(rq.az, c, s);
    nx = round_sat(x * c, -(y * s));
    ny = round_sat(y * c, x * s);
    res.rx = CW'(nx); res.ry = CW'(ny); res.rz = CW'(z);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_request(request_t rq);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_point_x <= rq.px; in_point_y <= rq.py; in_point_z <= rq.pz;
    in_angle_x <= rq.ax; in_angle_y <= rq.ay; in_angle_z <= rq.az;
    in_valid <= 1'b1;
    expected_points.push_back(rotate_point(rq));
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n) out_stall <= !calm && ($urandom_range(99) < 23);
  end

  always @(posedge clk) begin
    rotated_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected", out_rotated_x, '0);
      end else begin
        want = expected_points.pop_front();
        if (out_rotated_x !== want.rx) report_mismatch("x", out_rotated_x, want.rx);
        if (out_rotated_y !== want.ry) report_mismatch("y", out_rotated_y, want.ry);
        if (out_rotated_z !== want.rz) report_mismatch("z", out_rotated_z, want.rz);
      end
    end
  end

  function automatic logic [CW-1:0] random_coord();
    case ($urandom_range(3))
      0: return CW'($signed($urandom_range(2097152)) - 1048576);
      1: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(15)
                                  : 32'h80000000 + $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [AW-1:0] random_angle();
    case ($urandom_range(4))
      0: return AW'($urandom_range(3) << 14) + AW'($urandom_range(2)) - 16'd1;
      1: return AW'($urandom_range(7) << 13);
      default: return AW'($urandom);
    endcase
  endfunction

  task automatic test_zero_angles();
    send_request('{32'h00010000, 32'hFFFF0000, 32'h12345678, 16'h0, 16'h0, 16'h0});
    send_request('{32'h7FFFFFFF, 32'h80000000, 32'h0, 16'h0, 16'h0, 16'h0});
  endtask

  task automatic test_quadrants();
    for (int i = 0; i < 8; i++)
      send_request('{32'h00010000, 32'h00020000, 32'hFFFD0000,
                     AW'(i << 13), AW'((7 - i) << 13), AW'(i * 16'h2001)});
  endtask

  task automatic test_saturation();
    send_request('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000, 16'h2000, 16'h2000});
    send_request('{32'h80000000, 32'h80000000, 32'h80000000, 16'hE000, 16'hE000, 16'hE000});
    send_request('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 16'h8000, 16'h7FFF});
    send_request('{32'hFFFFFFFF, 32'h00000001, 32'hAAAAAAAA, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_request('{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 16'h5555, 16'hAAAA, 16'h1FFF});
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 3 + 250);
      send_request('{random_coord(), random_coord(), random_coord(),
                     random_angle(), random_angle(), random_angle()});
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_zero_angles();
    test_quadrants();
    test_saturation();
    test_random(1735);
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("euler_xyz_vector_rotation_top verification clean");
    end else begin
      $display("euler_xyz_vector_rotation_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("euler_xyz_vector_rotation_top verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/evr_pkg.sv
rtl/evr_trig.sv
rtl/evr_fifo.sv
rtl/evr_rot.sv
rtl/euler_xyz_vector_rotation_top.sv
verif/tb_euler_xyz_vector_rotation_top.sv
